[rtl/core/aipt_pkg.sv]
package aipt_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int BW        = DW + 2;
    localparam int ADJ_W     = 2 * DW + 1;
    localparam int ACC_W     = 128;
    localparam int MCNT_W    = $clog2(BW);
    localparam int DCNT_W    = $clog2(ACC_W);
    localparam int STEP_W    = 5;

    localparam logic [MCNT_W-1:0] MAC_LAST = MCNT_W'(BW - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(ACC_W - 1);

    // Affine tolerance and singular limit
    localparam logic [DW:0] TOL = (DW + 1)'((64'd1 << FRAC_BITS) / 64'd1000000);
    localparam logic [DW:0] ONE_FX = (DW + 1)'(64'd1 << FRAC_BITS);
    localparam logic [ACC_W-1:0] SING_LIM =
        (128'd1 << (3 * FRAC_BITS)) / 128'd1000000000000;

    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW - 1){1'b0}}};

    // Item modes
    localparam logic [1:0] MODE_MAT = 2'd0;
    localparam logic [1:0] MODE_PT  = 2'd1;
    localparam logic [1:0] MODE_RUN = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_AFFINE = 2'd1;
    localparam logic [1:0] ST_SINGULAR   = 2'd2;
    localparam logic [1:0] ST_OVF        = 2'd3;

    // Cofactor operand indexes: a, b, c, d of a*b - c*d, one nibble each
    localparam logic [15:0] COF_IDX [9] = '{
        16'h5A96, 16'h864A, 16'h4985,
        16'h921A, 16'h0A82, 16'h8109,
        16'h1652, 16'h4206, 16'h0541
    };

    typedef struct packed {
        logic [1:0]             mode;
        logic [3:0]             slot;
        logic signed [DW-1:0]   value;
    } in_item_t;

    typedef struct packed {
        logic signed [DW-1:0]   object_x;
        logic signed [DW-1:0]   object_y;
        logic signed [DW-1:0]   object_z;
        logic [1:0]             status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LOADA, S_LOADB, S_MAC, S_POST, S_CHK,
        S_DABS, S_DSET, S_DIV, S_DFIN, S_EMIT
    } state_t;

    typedef enum logic [1:0] {DST_NONE, DST_ADJ, DST_DET, DST_NUM} dst_t;

    typedef struct packed {
        logic       a_adj;
        logic [3:0] a_idx;
        logic       b_t;
        logic [3:0] b_idx;
        logic       neg;
        logic       clr;
        dst_t       dst;
    } step_t;

    // Operand selection for each multiply-accumulate step
    function automatic step_t step_decode(input logic [STEP_W-1:0] k);
        step_t s;
        logic [3:0] c;
        logic [15:0] e;
        s.a_adj = 1'b0;
        s.a_idx = 4'd0;
        s.b_t   = 1'b0;
        s.b_idx = 4'd0;
        s.neg   = 1'b0;
        s.clr   = 1'b0;
        s.dst   = DST_NONE;
        c = k[4:1];
        e = 16'd0;
        if (k < STEP_W'(18))
        begin
            e = COF_IDX[c];
            if (!k[0])
            begin
                s.a_idx = e[15:12];
                s.b_idx = e[11:8];
                s.clr   = 1'b1;
            end
            else
            begin
                s.a_idx = e[7:4];
                s.b_idx = e[3:0];
                s.neg   = 1'b1;
                s.dst   = DST_ADJ;
            end
        end
        else
        begin
            s.a_adj = 1'b1;
            unique case (k)
                5'd18: begin s.a_idx = 4'd0; s.b_idx = 4'd0; s.clr = 1'b1; end
                5'd19: begin s.a_idx = 4'd3; s.b_idx = 4'd4; end
                5'd20: begin s.a_idx = 4'd6; s.b_idx = 4'd8; s.dst = DST_DET; end
                5'd21: begin s.a_idx = 4'd0; s.b_idx = 4'd12; s.b_t = 1'b1; s.clr = 1'b1; end
                5'd22: begin s.a_idx = 4'd1; s.b_idx = 4'd13; s.b_t = 1'b1; end
                5'd23: begin s.a_idx = 4'd2; s.b_idx = 4'd14; s.b_t = 1'b1; s.dst = DST_NUM; end
                5'd24: begin s.a_idx = 4'd3; s.b_idx = 4'd12; s.b_t = 1'b1; s.clr = 1'b1; end
                5'd25: begin s.a_idx = 4'd4; s.b_idx = 4'd13; s.b_t = 1'b1; end
                5'd26: begin s.a_idx = 4'd5; s.b_idx = 4'd14; s.b_t = 1'b1; s.dst = DST_NUM; end
                5'd27: begin s.a_idx = 4'd6; s.b_idx = 4'd12; s.b_t = 1'b1; s.clr = 1'b1; end
                5'd28: begin s.a_idx = 4'd7; s.b_idx = 4'd13; s.b_t = 1'b1; end
                5'd29: begin s.a_idx = 4'd8; s.b_idx = 4'd14; s.b_t = 1'b1; s.dst = DST_NUM; end
                default: s.a_adj = 1'b1;
            endcase
        end
        return s;
    endfunction

endpackage

[rtl/core/affine_inverse_point_transform.sv]
// Affine inverse point transform. Load items (matrix element or point
// coordinate) are taken in the idle state and may be accepted while a
// result still waits at the output. A compute item runs 30 products through
// a bit-serial multiply-accumulate unit (operand A load, operand B load,
// multiply and store steps each), then for each axis a bit-serial restoring
// divider. A non-affine matrix skips all steps; a singular one stops at the
// determinant check. No new item is accepted until the result is registered.
module affine_inverse_point_transform (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aipt_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aipt_pkg::out_item_t  out_data
);
    import aipt_pkg::*;

    state_t                    state_reg, state_next;
    logic signed [DW-1:0]      mat_reg [16];
    logic signed [DW-1:0]      pt_reg [3];
    logic signed [ADJ_W-1:0]   adj_reg [9];
    logic signed [ACC_W-1:0]   acc_reg, a_reg, det_reg;
    logic [ACC_W-1:0]          mdet_reg, rem_reg;
    logic signed [BW-1:0]      b_reg;
    logic [MCNT_W-1:0]         mcnt_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [1:0]                axis_reg;
    logic [DW:0]               q_reg;
    logic                      big_reg, neg_reg;
    logic signed [DW-1:0]      res_reg [3];
    logic [1:0]                stat_reg;
    out_item_t                 out_reg;
    logic                      out_valid_reg;

    step_t                     cur;
    logic                      accept, run_acc, emit_go;
    logic                      not_affine, singular;
    logic signed [DW:0]        d15;
    logic [DW:0]               mag3, mag7, mag11, mag15;
    logic                      mbit, msub;
    logic signed [ACC_W-1:0]   addend, acc_mac;
    logic [ACC_W-1:0]          det_abs, rem_sh, dvs, rem_new;
    logic                      ge;
    logic signed [DW:0]        tval;
    logic                      sat_big;
    logic signed [DW-1:0]      sat_val;

    assign cur     = step_decode(step_reg);
    assign accept  = in_valid & in_ready;
    assign run_acc = accept && (in_data.mode == MODE_RUN);
    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // Affine test on the bottom row
    always_comb
    begin
        d15   = {mat_reg[15][DW-1], mat_reg[15]} - $signed(ONE_FX);
        mag3  = mat_reg[3][DW-1]  ? -{mat_reg[3][DW-1], mat_reg[3]}
                                  : {mat_reg[3][DW-1], mat_reg[3]};
        mag7  = mat_reg[7][DW-1]  ? -{mat_reg[7][DW-1], mat_reg[7]}
                                  : {mat_reg[7][DW-1], mat_reg[7]};
        mag11 = mat_reg[11][DW-1] ? -{mat_reg[11][DW-1], mat_reg[11]}
                                  : {mat_reg[11][DW-1], mat_reg[11]};
        mag15 = d15[DW] ? -d15 : d15;
        not_affine = (mag3 > TOL) || (mag7 > TOL) || (mag11 > TOL) || (mag15 > TOL);
    end

    // Bit-serial multiply-accumulate, sign bit of the multiplier weighs negative
    always_comb
    begin
        mbit    = b_reg[0];
        msub    = cur.neg ^ (mcnt_reg == MAC_LAST);
        addend  = mbit ? (a_reg ^ {ACC_W{msub}}) : '0;
        acc_mac = acc_reg + addend + ACC_W'(mbit & msub);
    end

    // Determinant magnitude and singular test
    assign det_abs  = det_reg[ACC_W-1] ? -det_reg : det_reg;
    assign singular = det_abs <= SING_LIM;

    // Restoring division step
    always_comb
    begin
        rem_sh  = {rem_reg[ACC_W-2:0], acc_reg[ACC_W-1]};
        dvs     = {mdet_reg[ACC_W-2:0], 1'b0};
        ge      = rem_sh >= dvs;
        rem_new = ge ? (rem_sh - dvs) : rem_sh;
    end

    // Translated coordinate for the numerator products
    assign tval = {pt_reg[cur.b_idx[1:0]][DW-1], pt_reg[cur.b_idx[1:0]]}
                - {mat_reg[cur.b_idx][DW-1], mat_reg[cur.b_idx]};

    // Saturate the quotient magnitude and apply the sign
    always_comb
    begin
        if (neg_reg)
        begin
            sat_big = big_reg | q_reg[DW] | (q_reg[DW-1] & (|q_reg[DW-2:0]));
            sat_val = sat_big ? SAT_MIN : -$signed(q_reg[DW-1:0]);
        end
        else
        begin
            sat_big = big_reg | q_reg[DW] | q_reg[DW-1];
            sat_val = sat_big ? SAT_MAX : $signed(q_reg[DW-1:0]);
        end
    end

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:  if (run_acc) state_next = not_affine ? S_EMIT : S_LOADA;
            S_LOADA: state_next = S_LOADB;
            S_LOADB: state_next = S_MAC;
            S_MAC:   if (mcnt_reg == MAC_LAST) state_next = S_POST;
            S_POST:
            begin
                priority if (cur.dst == DST_DET) state_next = S_CHK;
                else if (cur.dst == DST_NUM)    state_next = S_DABS;
                else                            state_next = S_LOADA;
            end
            S_CHK:   state_next = singular ? S_EMIT : S_LOADA;
            S_DABS:  state_next = S_DSET;
            S_DSET:  state_next = S_DIV;
            S_DIV:   if (dcnt_reg == DIV_LAST) state_next = S_DFIN;
            S_DFIN:  state_next = (axis_reg == 2'd2) ? S_EMIT : S_LOADA;
            S_EMIT:  if (emit_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Control state and stored matrix and point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
            for (int i = 0; i < 3; i++) pt_reg[i] <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            axis_reg      <= '0;
            mcnt_reg      <= '0;
            dcnt_reg      <= '0;
            stat_reg      <= ST_OK;
        end
        else
        begin
            if (accept && in_data.mode == MODE_MAT)
                mat_reg[in_data.slot] <= in_data.value;
            if (accept && in_data.mode == MODE_PT && in_data.slot < 4'd3)
                pt_reg[in_data.slot[1:0]] <= in_data.value;
            out_valid_reg <= emit_go | (out_valid_reg & ~out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (run_acc)
                    begin
                        step_reg <= '0;
                        axis_reg <= '0;
                        stat_reg <= not_affine ? ST_NOT_AFFINE : ST_OK;
                    end
                end
                S_LOADB: mcnt_reg <= '0;
                S_MAC:   mcnt_reg <= mcnt_reg + 1'b1;
                S_POST:  step_reg <= step_reg + 1'b1;
                S_CHK:   if (singular) stat_reg <= ST_SINGULAR;
                S_DSET:  dcnt_reg <= '0;
                S_DIV:   dcnt_reg <= dcnt_reg + 1'b1;
                S_DFIN:
                begin
                    axis_reg <= axis_reg + 1'b1;
                    if (sat_big) stat_reg <= ST_OVF;
                end
                default: ;
            endcase
        end
    end

    // Datapath: operands, accumulator, divider and results
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (run_acc)
                    for (int i = 0; i < 3; i++) res_reg[i] <= '0;
            end
            S_LOADA:
            begin
                a_reg <= cur.a_adj ? ACC_W'(adj_reg[cur.a_idx]) : ACC_W'(mat_reg[cur.a_idx]);
                if (cur.clr) acc_reg <= '0;
            end
            S_LOADB: b_reg <= cur.b_t ? BW'(tval) : BW'(mat_reg[cur.b_idx]);
            S_MAC:
            begin
                acc_reg <= acc_mac;
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >>> 1;
            end
            S_POST:
            begin
                if (cur.dst == DST_ADJ) adj_reg[step_reg[4:1]] <= acc_reg[ADJ_W-1:0];
                if (cur.dst == DST_DET) det_reg <= acc_reg;
            end
            S_CHK: mdet_reg <= det_abs;
            S_DABS:
            begin
                neg_reg <= acc_reg[ACC_W-1] ^ det_reg[ACC_W-1];
                acc_reg <= acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
            end
            S_DSET:
            begin
                acc_reg <= (acc_reg <<< (FRAC_BITS + 1)) + $signed(mdet_reg);
                rem_reg <= '0;
                q_reg   <= '0;
                big_reg <= 1'b0;
            end
            S_DIV:
            begin
                rem_reg <= rem_new;
                acc_reg <= acc_reg <<< 1;
                q_reg   <= {q_reg[DW-1:0], ge};
                big_reg <= big_reg | q_reg[DW];
            end
            S_DFIN: res_reg[axis_reg] <= sat_val;
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_reg.object_x <= res_reg[0];
                    out_reg.object_y <= res_reg[1];
                    out_reg.object_z <= res_reg[2];
                    out_reg.status   <= stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_mac_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (mcnt_reg <= MAC_LAST))
        else $error("mac bit counter past last bit");

    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        run_acc |=> !in_ready)
        else $error("input accepted during compute");

    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == ST_NOT_AFFINE ||
                           out_reg.status == ST_SINGULAR)) |->
        (out_reg.object_x == '0 && out_reg.object_y == '0 && out_reg.object_z == '0))
        else $error("failed transform with nonzero coordinates");

endmodule
